@@ src/isr_pkg.sv @@
// ----------------------------------------------------------------------------
// isr_pkg: shared types for the interval set engine
// Operation kinds, cell commands and the status flags that each cell of the
// range chain shows to its neighbors and to the controller.
// ----------------------------------------------------------------------------
package isr_pkg;

	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_CLIP   = 3'd2;
	localparam logic [2:0] KIND_SHIFT  = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;
	localparam logic [2:0] KIND_POINT  = 3'd5;
	localparam logic [2:0] KIND_RANGE  = 3'd6;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADD_INS,
		OP_ADD_MERGE,
		OP_REMOVE,
		OP_SPLIT,
		OP_CLIP,
		OP_SHIFT,
		OP_CLEAR,
		OP_COMPACT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic add_mode;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic mv;
		logic merge;
		logic split;
		logic le;
	} flags_t;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EXEC    = 4'b0010,
		S_COMPACT = 4'b0100,
		S_REPORT  = 4'b1000
	} state_t;

endpackage

@@ src/interval_set_engine.sv @@
// ----------------------------------------------------------------------------
// interval_set_engine: sorted set of disjoint inclusive ranges
// A transaction passes through the EXEC, COMPACT and REPORT states; COMPACT
// repeats one compaction step while gaps travel to the end of the chain, and
// REPORT waits while an unaccepted result is held. One item at a time: the next
// transaction is taken only after the result has been registered. Reset empties
// the set; range bounds are not cleared.
// ----------------------------------------------------------------------------
module interval_set_engine #(
	parameter int MAX_RANGES  = 64,
	parameter int BOUND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] range_begin,
	input  logic signed [31:0] range_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [6:0]  found_index,
	output logic [6:0]         ranges_held,
	output logic               overflow,
	output logic signed [31:0] span_begin,
	output logic signed [31:0] span_end
);

	localparam int N  = MAX_RANGES;
	localparam int BW = BOUND_WIDTH;
	localparam int W  = ((BW > 32) ? BW : 32) + 2;
	localparam logic signed [W-1:0] BMAX = signed'({{(W-BW+1){1'b0}}, {(BW-1){1'b1}}});
	localparam logic signed [W-1:0] BMIN = -BMAX - W'(1);

	isr_pkg::state_t       state_q;
	isr_pkg::cmd_t         cmd;
	isr_pkg::op_t          op_exec;
	isr_pkg::flags_t       fl [N];
	logic signed [BW-1:0]  cs [N];
	logic signed [BW-1:0]  ct [N];
	logic [2:0]            kind_q;
	logic signed [31:0]    b_q, e_q;
	logic signed [W-1:0]   arg_b, arg_e, m_stop, t_last, t_sel, s_first;
	logic                  ovf_q, ovf_exec, any_merge, any_split, need_c;
	logic [N-1:0]          v_vec, le_vec;
	int                    le_cnt, tot_cnt, idx_val;
	logic                  hit_val;

	assign arg_b = W'(b_q);
	assign arg_e = W'(e_q);
	assign in_ready = (state_q == isr_pkg::S_IDLE);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			isr_pkg::flags_t      lf;
			logic signed [BW-1:0] ls, lt, rs, rt;
			logic                 rv;
			if (g == 0) begin : g_first
				assign lf = '{valid: 1'b1, mv: 1'b0, merge: 1'b0, split: 1'b0, le: 1'b0};
				assign ls = '0;
				assign lt = '0;
			end else begin : g_mid
				assign lf = fl[g-1];
				assign ls = cs[g-1];
				assign lt = ct[g-1];
			end
			if (g == N - 1) begin : g_last
				assign rv = 1'b0;
				assign rs = '0;
				assign rt = '0;
			end else begin : g_nxt
				assign rv = fl[g+1].valid;
				assign rs = cs[g+1];
				assign rt = ct[g+1];
			end
			isr_cell #(.BW(BW), .W(W)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.arg_b(arg_b), .arg_e(arg_e), .m_stop(m_stop),
				.lf(lf), .ls(ls), .lt(lt), .rv(rv), .rs(rs), .rt(rt),
				.f(fl[g]), .s_q(cs[g]), .t_q(ct[g])
			);
		end
	endgenerate

	always_comb begin
		any_merge = 1'b0;
		any_split = 1'b0;
		need_c = 1'b0;
		m_stop = '0;
		t_last = '0;
		t_sel = '0;
		for (int i = 0; i < N; i++) begin
			v_vec[i] = fl[i].valid;
			le_vec[i] = fl[i].le;
			any_merge = any_merge | fl[i].merge;
			any_split = any_split | fl[i].split;
			if (i < N - 1) begin
				need_c = need_c | (!fl[i].valid && fl[i+1].valid);
				if (fl[i].merge && !fl[i+1].merge) m_stop = m_stop | W'(ct[i]);
				if (fl[i].valid && !fl[i+1].valid) t_last = t_last | W'(ct[i]);
				if (fl[i].le && !fl[i+1].le) t_sel = t_sel | W'(ct[i]);
			end else begin
				if (fl[i].merge) m_stop = m_stop | W'(ct[i]);
				if (fl[i].valid) t_last = t_last | W'(ct[i]);
				if (fl[i].le) t_sel = t_sel | W'(ct[i]);
			end
		end
		s_first = fl[0].valid ? W'(cs[0]) : '0;
	end

	always_comb begin
		op_exec = isr_pkg::OP_NONE;
		ovf_exec = 1'b0;
		case (kind_q)
			isr_pkg::KIND_ADD: begin
				if (arg_e >= arg_b) begin
					if (arg_b < BMIN || arg_b > BMAX || arg_e < BMIN || arg_e > BMAX) begin
						ovf_exec = 1'b1;
					end else if (any_merge) begin
						op_exec = isr_pkg::OP_ADD_MERGE;
					end else if (fl[N-1].valid) begin
						ovf_exec = 1'b1;
					end else begin
						op_exec = isr_pkg::OP_ADD_INS;
					end
				end
			end
			isr_pkg::KIND_REMOVE: begin
				if (arg_e >= arg_b) begin
					if (!any_split) begin
						op_exec = isr_pkg::OP_REMOVE;
					end else if (fl[N-1].valid) begin
						ovf_exec = 1'b1;
					end else begin
						op_exec = isr_pkg::OP_SPLIT;
					end
				end
			end
			isr_pkg::KIND_CLIP: begin
				if (fl[0].valid) begin
					op_exec = (arg_e < arg_b) ? isr_pkg::OP_CLEAR : isr_pkg::OP_CLIP;
				end
			end
			isr_pkg::KIND_SHIFT: begin
				if (fl[0].valid) begin
					if ((arg_b < 0 && s_first + arg_b < BMIN) ||
					    (arg_b > 0 && t_last + arg_b > BMAX)) begin
						ovf_exec = 1'b1;
					end else begin
						op_exec = isr_pkg::OP_SHIFT;
					end
				end
			end
			isr_pkg::KIND_CLEAR: begin
				op_exec = isr_pkg::OP_CLEAR;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.add_mode = (kind_q == isr_pkg::KIND_ADD);
		case (state_q)
			isr_pkg::S_EXEC:    cmd.op = op_exec;
			isr_pkg::S_COMPACT: cmd.op = need_c ? isr_pkg::OP_COMPACT : isr_pkg::OP_NONE;
			default:            cmd.op = isr_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		le_cnt = $countones(le_vec);
		tot_cnt = $countones(v_vec);
		idx_val = -1;
		hit_val = 1'b0;
		if (kind_q == isr_pkg::KIND_POINT) begin
			idx_val = le_cnt - 1;
			hit_val = (le_cnt > 0) && (t_sel >= arg_b);
		end else if (kind_q == isr_pkg::KIND_RANGE) begin
			idx_val = le_cnt - 1;
			hit_val = (arg_e >= arg_b) && (le_cnt > 0) && (t_sel >= arg_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isr_pkg::S_IDLE;
			out_valid <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				isr_pkg::S_IDLE: begin
					if (in_valid) state_q <= isr_pkg::S_EXEC;
				end
				isr_pkg::S_EXEC: begin
					ovf_q <= ovf_exec;
					state_q <= isr_pkg::S_COMPACT;
				end
				isr_pkg::S_COMPACT: begin
					if (!need_c) state_q <= isr_pkg::S_REPORT;
				end
				isr_pkg::S_REPORT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q <= isr_pkg::S_IDLE;
					end
				end
				default: state_q <= isr_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			b_q <= range_begin;
			e_q <= range_end;
		end
		if (state_q == isr_pkg::S_REPORT && (!out_valid || out_ready)) begin
			hit <= hit_val;
			found_index <= idx_val[6:0];
			ranges_held <= tot_cnt[6:0];
			overflow <= ovf_q;
			span_begin <= s_first[31:0];
			span_end <= t_last[31:0];
		end
	end

endmodule

@@ src/isr_cell.sv @@
// ----------------------------------------------------------------------------
// isr_cell: one range slot of the chain
// Holds one range and a valid bit, classifies it against the command bounds
// and takes its next value from itself, from a neighbor or from the command bounds.
// ----------------------------------------------------------------------------
module isr_cell #(
	parameter int BW = 32,
	parameter int W  = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isr_pkg::cmd_t         cmd,
	input  logic signed [W-1:0]   arg_b,
	input  logic signed [W-1:0]   arg_e,
	input  logic signed [W-1:0]   m_stop,
	input  isr_pkg::flags_t       lf,
	input  logic signed [BW-1:0]  ls,
	input  logic signed [BW-1:0]  lt,
	input  logic                  rv,
	input  logic signed [BW-1:0]  rs,
	input  logic signed [BW-1:0]  rt,
	output isr_pkg::flags_t       f,
	output logic signed [BW-1:0]  s_q,
	output logic signed [BW-1:0]  t_q
);

	logic                valid_q;
	logic signed [W-1:0] sx, tx, be1, ee1, cs, ct, n_s, n_t;
	logic                n_v, is_below, is_above;

	always_comb begin
		sx = W'(s_q);
		tx = W'(t_q);
		be1 = arg_b - W'(1);
		ee1 = arg_e + W'(1);
		is_below = tx < be1;
		is_above = sx > ee1;
		f.valid = valid_q;
		f.merge = valid_q && !is_below && !is_above;
		f.mv = valid_q && (cmd.add_mode ? is_above : (sx > arg_e));
		f.split = valid_q && (sx < arg_b) && (tx > arg_e);
		f.le = valid_q && (sx <= arg_b);
		cs = (sx > arg_b) ? sx : arg_b;
		ct = (tx < arg_e) ? tx : arg_e;
	end

	always_comb begin
		n_s = sx;
		n_t = tx;
		n_v = valid_q;
		case (cmd.op)
			isr_pkg::OP_ADD_INS: begin
				if (lf.mv) begin
					n_s = W'(ls);
					n_t = W'(lt);
					n_v = 1'b1;
				end else if ((f.mv || !valid_q) && lf.valid) begin
					n_s = arg_b;
					n_t = arg_e;
					n_v = 1'b1;
				end
			end
			isr_pkg::OP_ADD_MERGE: begin
				if (f.merge && !lf.merge) begin
					n_s = (sx < arg_b) ? sx : arg_b;
					n_t = (m_stop > arg_e) ? m_stop : arg_e;
				end else if (f.merge) begin
					n_v = 1'b0;
				end
			end
			isr_pkg::OP_REMOVE: begin
				if (valid_q && !(tx < arg_b || sx > arg_e)) begin
					if (sx < arg_b) begin
						n_t = be1;
					end else if (tx > arg_e) begin
						n_s = ee1;
					end else begin
						n_v = 1'b0;
					end
				end
			end
			isr_pkg::OP_SPLIT: begin
				if (f.split) begin
					n_t = be1;
				end else if (lf.split) begin
					n_s = ee1;
					n_t = W'(lt);
					n_v = 1'b1;
				end else if (lf.mv) begin
					n_s = W'(ls);
					n_t = W'(lt);
					n_v = 1'b1;
				end
			end
			isr_pkg::OP_CLIP: begin
				if (valid_q) begin
					n_s = cs;
					n_t = ct;
					n_v = cs <= ct;
				end
			end
			isr_pkg::OP_SHIFT: begin
				if (valid_q) begin
					n_s = sx + arg_b;
					n_t = tx + arg_b;
				end
			end
			isr_pkg::OP_CLEAR: begin
				n_v = 1'b0;
			end
			isr_pkg::OP_COMPACT: begin
				if (!valid_q) begin
					n_s = W'(rs);
					n_t = W'(rt);
					n_v = rv;
				end else if (!lf.valid) begin
					n_v = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= n_v;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= n_s[BW-1:0];
		t_q <= n_t[BW-1:0];
	end

endmodule
